@@ hw/rtl/ftp_command_line_tokenizer_core_defines.svh @@
// Assertion macros shared by the FTP command line tokenizer RTL.
// Depends on nothing; the asserting modules pull this file in.
`ifndef FTP_COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define FTP_COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTH

// Property checked on every rising edge outside reset
`define FTPCLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset
`define FTPCLT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`else

`define FTPCLT_ASSERT(lbl, prop, msg)
`define FTPCLT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hw/rtl/ftpclt_pkg.sv @@
// Types and constants for the FTP command line tokenizer.
// Depends on nothing; used by ftp_command_line_tokenizer_core.
package ftpclt_pkg;

    // Result field widths
    localparam int BYTE_CLASS_W   = 4;
    localparam int TOKEN_KIND_W   = 2;
    localparam int TOKEN_LENGTH_W = 10;
    localparam int ARG_INDEX_W    = 4;

    // Control bytes of the stream
    localparam logic [7:0] BYTE_IAC = 8'hFF;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_SKIP  = 5'b00001,
        PH_NAME  = 5'b00010,
        PH_SPACE = 5'b00100,
        PH_ARG   = 5'b01000,
        PH_CR    = 5'b10000
    } t_phase;

    // Byte classification codes
    typedef enum logic [BYTE_CLASS_W-1:0] {
        CLS_TELNET    = 4'd0,
        CLS_NAME      = 4'd1,
        CLS_NAME_END  = 4'd2,
        CLS_SEPARATOR = 4'd3,
        CLS_ARG       = 4'd4,
        CLS_ARG_END   = 4'd5,
        CLS_CR        = 4'd6,
        CLS_LF_DONE   = 4'd7,
        CLS_INVALID   = 4'd8
    } t_byte_class;

    // Kind of token closed by a byte
    typedef enum logic [TOKEN_KIND_W-1:0] {
        TOK_NONE = 2'd0,
        TOK_NAME = 2'd1,
        TOK_ARG  = 2'd2
    } t_token_kind;

endpackage

@@ hw/rtl/ftp_command_line_tokenizer_core.sv @@
// FTP command line tokenizer: takes one control stream byte per transfer and
// returns one classification result per byte. The block sustains one byte per
// clock cycle while the result channel does not stall; a byte's result reaches
// the output through the input register, then the result register, and the whole
// parser update for one byte is combinational logic between those two registers. A result
// waiting on a stalled output does not block the input: one more byte is held in
// the input register before the input stall rises. Token lengths saturate at
// TOKEN_LEN_MAX and argument counts at ARG_COUNT_MAX; the result fields carry
// the low bits of the saturated counts.
// Depends on ftpclt_pkg and ftp_command_line_tokenizer_core_defines.svh.
`include "ftp_command_line_tokenizer_core_defines.svh"

module ftp_command_line_tokenizer_core #(
    parameter int TOKEN_LEN_MAX = 1023,
    parameter int ARG_COUNT_MAX = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input byte channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [7:0]                            i_data_byte,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ftpclt_pkg::BYTE_CLASS_W-1:0]   o_byte_class,
    output logic [ftpclt_pkg::TOKEN_KIND_W-1:0]   o_token_kind,
    output logic [ftpclt_pkg::TOKEN_LENGTH_W-1:0] o_token_length,
    output logic [ftpclt_pkg::ARG_INDEX_W-1:0]    o_arg_index
);

    localparam int LEN_W  = $clog2(TOKEN_LEN_MAX + 1);
    localparam int ARGC_W = $clog2(ARG_COUNT_MAX + 1);
    localparam int LEN_XW = (LEN_W > ftpclt_pkg::TOKEN_LENGTH_W) ?
                            LEN_W : ftpclt_pkg::TOKEN_LENGTH_W;
    localparam int ARGC_XW = (ARGC_W > ftpclt_pkg::ARG_INDEX_W) ?
                             ARGC_W : ftpclt_pkg::ARG_INDEX_W;
    localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(TOKEN_LEN_MAX);
    localparam logic [ARGC_W-1:0] ARGC_LIMIT = ARGC_W'(ARG_COUNT_MAX);
    localparam logic [LEN_W-1:0]  LEN_ONE    = LEN_W'(1);
    localparam logic [ARGC_W-1:0] ARGC_ONE   = ARGC_W'(1);
    localparam logic [1:0]        SKIP_TWO   = 2'd2;

    // pipeline registers
    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_out_valid;
    ftpclt_pkg::t_byte_class        r_out_class;
    ftpclt_pkg::t_token_kind        r_out_kind;
    logic [LEN_W-1:0]               r_out_len;
    logic [ARGC_W-1:0]              r_out_argc;

    // parser state
    ftpclt_pkg::t_phase             r_phase;
    ftpclt_pkg::t_phase             n_phase;
    logic [1:0]                     r_skip;
    logic [1:0]                     n_skip;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               n_len;
    logic [ARGC_W-1:0]              r_argc;
    logic [ARGC_W-1:0]              n_argc;

    // result of the byte in the input register
    ftpclt_pkg::t_byte_class        w_class;
    ftpclt_pkg::t_token_kind        w_kind;
    logic [LEN_W-1:0]               w_len;
    logic [ARGC_W-1:0]              w_argc;

    logic                           w_out_free;
    logic                           w_proc;
    logic                           w_is_sp;
    logic                           w_is_cr;
    logic                           w_is_lf;
    logic [LEN_XW-1:0]              w_len_ext;
    logic [ARGC_XW-1:0]             w_argc_ext;

    // handshake: result register frees when empty or being taken
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    assign w_is_sp = (r_in_byte == ftpclt_pkg::BYTE_SP);
    assign w_is_cr = (r_in_byte == ftpclt_pkg::BYTE_CR);
    assign w_is_lf = (r_in_byte == ftpclt_pkg::BYTE_LF);

    // parser update for one byte
    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        n_len   = r_len;
        n_argc  = r_argc;
        w_class = ftpclt_pkg::CLS_TELNET;
        w_kind  = ftpclt_pkg::TOK_NONE;
        w_len   = '0;
        case (r_phase)
            ftpclt_pkg::PH_NAME: begin
                if (w_is_sp || w_is_cr) begin
                    if (w_is_sp) begin
                        w_class = ftpclt_pkg::CLS_NAME_END;
                        n_phase = ftpclt_pkg::PH_SPACE;
                    end else begin
                        w_class = ftpclt_pkg::CLS_CR;
                        n_phase = ftpclt_pkg::PH_CR;
                    end
                    w_kind  = ftpclt_pkg::TOK_NAME;
                    w_len   = r_len;
                    n_len   = '0;
                end else begin
                    w_class = ftpclt_pkg::CLS_NAME;
                    if (r_len != LEN_LIMIT) begin
                        n_len = r_len + LEN_ONE;
                    end
                end
            end
            ftpclt_pkg::PH_SPACE: begin
                if (w_is_cr) begin
                    w_class = ftpclt_pkg::CLS_CR;
                    n_phase = ftpclt_pkg::PH_CR;
                end else if (w_is_sp) begin
                    w_class = ftpclt_pkg::CLS_SEPARATOR;
                end else begin
                    w_class = ftpclt_pkg::CLS_ARG;
                    n_len   = LEN_ONE;
                    n_phase = ftpclt_pkg::PH_ARG;
                end
            end
            ftpclt_pkg::PH_ARG: begin
                if (w_is_sp || w_is_cr) begin
                    if (w_is_sp) begin
                        w_class = ftpclt_pkg::CLS_ARG_END;
                        n_phase = ftpclt_pkg::PH_SPACE;
                    end else begin
                        w_class = ftpclt_pkg::CLS_CR;
                        n_phase = ftpclt_pkg::PH_CR;
                    end
                    w_kind  = ftpclt_pkg::TOK_ARG;
                    w_len   = r_len;
                    n_len   = '0;
                    if (r_argc != ARGC_LIMIT) begin
                        n_argc = r_argc + ARGC_ONE;
                    end
                end else begin
                    w_class = ftpclt_pkg::CLS_ARG;
                    if (r_len != LEN_LIMIT) begin
                        n_len = r_len + LEN_ONE;
                    end
                end
            end
            ftpclt_pkg::PH_CR: begin
                // LF completes the command, anything else is invalid; both restart
                if (w_is_lf) begin
                    w_class = ftpclt_pkg::CLS_LF_DONE;
                end else begin
                    w_class = ftpclt_pkg::CLS_INVALID;
                end
                n_phase = ftpclt_pkg::PH_SKIP;
                n_skip  = '0;
                n_len   = '0;
                n_argc  = '0;
            end
            default: begin
                // start phase: skip telnet commands, then open the name
                n_phase = ftpclt_pkg::PH_SKIP;
                if (r_skip != 2'd0) begin
                    n_skip  = r_skip - 2'd1;
                    w_class = ftpclt_pkg::CLS_TELNET;
                end else if (r_in_byte == ftpclt_pkg::BYTE_IAC) begin
                    n_skip  = SKIP_TWO;
                    w_class = ftpclt_pkg::CLS_TELNET;
                end else begin
                    w_class = ftpclt_pkg::CLS_NAME;
                    n_len   = LEN_ONE;
                    n_phase = ftpclt_pkg::PH_NAME;
                end
            end
        endcase
        // a finished command reports its count before the restart
        w_argc = (w_class == ftpclt_pkg::CLS_LF_DONE) ? r_argc : n_argc;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= ftpclt_pkg::PH_SKIP;
            r_skip      <= '0;
            r_len       <= '0;
            r_argc      <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_skip  <= n_skip;
                r_len   <= n_len;
                r_argc  <= n_argc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
        end
        if (w_proc) begin
            r_out_class <= w_class;
            r_out_kind  <= w_kind;
            r_out_len   <= w_len;
            r_out_argc  <= w_argc;
        end
    end

    // outputs carry the low bits of the saturated counts
    assign w_len_ext  = LEN_XW'(r_out_len);
    assign w_argc_ext = ARGC_XW'(r_out_argc);

    assign o_valid        = r_out_valid;
    assign o_byte_class   = r_out_class;
    assign o_token_kind   = r_out_kind;
    assign o_token_length = w_len_ext[ftpclt_pkg::TOKEN_LENGTH_W-1:0];
    assign o_arg_index    = w_argc_ext[ftpclt_pkg::ARG_INDEX_W-1:0];

    // checks
    `FTPCLT_ASSERT(a_no_token_no_len,
        (o_valid && o_token_kind == ftpclt_pkg::TOK_NONE) |-> (o_token_length == '0),
        "token length reported without a closed token")
    `FTPCLT_ASSERT(a_name_end_closes_name,
        (o_valid && o_byte_class == ftpclt_pkg::CLS_NAME_END) |->
            (o_token_kind == ftpclt_pkg::TOK_NAME),
        "name-ending space did not close the command name")
    `FTPCLT_ASSERT(a_restart_after_line,
        (w_proc && (w_class == ftpclt_pkg::CLS_LF_DONE ||
                    w_class == ftpclt_pkg::CLS_INVALID)) |=>
            (r_phase == ftpclt_pkg::PH_SKIP && r_argc == '0 && r_len == '0 &&
             r_skip == '0),
        "parser not back at start after end of line")
    `FTPCLT_ASSERT(a_held_byte_kept,
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_byte)),
        "held input byte lost while result register blocked")

endmodule

@@ test/testbench.sv @@
// Self-checking bench for ftp_command_line_tokenizer_core: drives control-stream bytes,
// predicts each byte's classification and compares every result transfer in order.
// Depends on ftpclt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int TOKEN_LIMIT  = 1023;
    localparam int ARG_LIMIT    = 15;
    localparam int STREAM_BYTES = 1100;
    localparam int HOLD_CYCLES  = 80;
    localparam int LONG_CMD     = 4;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct {
        ftpclt_pkg::t_byte_class cls;
        ftpclt_pkg::t_token_kind kind;
        logic [ftpclt_pkg::TOKEN_LENGTH_W-1:0] len;
        logic [ftpclt_pkg::ARG_INDEX_W-1:0] idx;
    } t_parse_result;

    // Tracks the parser phase of the stream and the results still owed by the block
    class line_parse_tracker;
        ftpclt_pkg::t_phase phase;
        logic [1:0] skip_left;
        int unsigned tok_len;
        int unsigned args_done;
        t_parse_result owed_q[$];
        int fail_count;

        function new();
            fail_count = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase = ftpclt_pkg::PH_SKIP;
            skip_left = '0;
            tok_len = 0;
            args_done = 0;
        endfunction

        function void bump_len();
            if (tok_len < TOKEN_LIMIT) tok_len++;
        endfunction

        // Classify one accepted byte and queue the result it must produce
        function void classify_byte(logic [7:0] b);
            t_parse_result r;
            r.cls = ftpclt_pkg::CLS_TELNET;
            r.kind = ftpclt_pkg::TOK_NONE;
            r.len = '0;
            r.idx = '0;
            case (phase)
                ftpclt_pkg::PH_NAME: begin
                    if (b == ftpclt_pkg::BYTE_SP || b == ftpclt_pkg::BYTE_CR) begin
                        if (b == ftpclt_pkg::BYTE_SP) begin
                            r.cls = ftpclt_pkg::CLS_NAME_END;
                            phase = ftpclt_pkg::PH_SPACE;
                        end else begin
                            r.cls = ftpclt_pkg::CLS_CR;
                            phase = ftpclt_pkg::PH_CR;
                        end
                        r.kind = ftpclt_pkg::TOK_NAME;
                        r.len = ftpclt_pkg::TOKEN_LENGTH_W'(tok_len);
                        tok_len = 0;
                    end else begin
                        r.cls = ftpclt_pkg::CLS_NAME;
                        bump_len();
                    end
                end
                ftpclt_pkg::PH_SPACE: begin
                    if (b == ftpclt_pkg::BYTE_CR) begin
                        r.cls = ftpclt_pkg::CLS_CR;
                        phase = ftpclt_pkg::PH_CR;
                    end else if (b == ftpclt_pkg::BYTE_SP) begin
                        r.cls = ftpclt_pkg::CLS_SEPARATOR;
                    end else begin
                        r.cls = ftpclt_pkg::CLS_ARG;
                        tok_len = 1;
                        phase = ftpclt_pkg::PH_ARG;
                    end
                end
                ftpclt_pkg::PH_ARG: begin
                    if (b == ftpclt_pkg::BYTE_SP || b == ftpclt_pkg::BYTE_CR) begin
                        if (b == ftpclt_pkg::BYTE_SP) begin
                            r.cls = ftpclt_pkg::CLS_ARG_END;
                            phase = ftpclt_pkg::PH_SPACE;
                        end else begin
                            r.cls = ftpclt_pkg::CLS_CR;
                            phase = ftpclt_pkg::PH_CR;
                        end
                        r.kind = ftpclt_pkg::TOK_ARG;
                        r.len = ftpclt_pkg::TOKEN_LENGTH_W'(tok_len);
                        tok_len = 0;
                        if (args_done < ARG_LIMIT) args_done++;
                    end else begin
                        r.cls = ftpclt_pkg::CLS_ARG;
                        bump_len();
                    end
                end
                ftpclt_pkg::PH_CR: begin
                    // LF reports the count of the finished command; anything else aborts it
                    if (b == ftpclt_pkg::BYTE_LF) begin
                        r.cls = ftpclt_pkg::CLS_LF_DONE;
                        r.idx = ftpclt_pkg::ARG_INDEX_W'(args_done);
                    end else begin
                        r.cls = ftpclt_pkg::CLS_INVALID;
                    end
                    clear_parser();
                end
                default: begin
                    phase = ftpclt_pkg::PH_SKIP;
                    if (skip_left != 0) begin
                        skip_left--;
                    end else if (b == ftpclt_pkg::BYTE_IAC) begin
                        skip_left = 2'd2;
                    end else begin
                        r.cls = ftpclt_pkg::CLS_NAME;
                        tok_len = 1;
                        phase = ftpclt_pkg::PH_NAME;
                    end
                end
            endcase
            if (r.cls != ftpclt_pkg::CLS_LF_DONE)
                r.idx = ftpclt_pkg::ARG_INDEX_W'(args_done);
            owed_q.push_back(r);
        endfunction

        // Compare one result transfer against the oldest owed result
        function void compare_result(logic [ftpclt_pkg::BYTE_CLASS_W-1:0] cls,
                                     logic [ftpclt_pkg::TOKEN_KIND_W-1:0] kind,
                                     logic [ftpclt_pkg::TOKEN_LENGTH_W-1:0] len,
                                     logic [ftpclt_pkg::ARG_INDEX_W-1:0] idx);
            t_parse_result e;
            if (owed_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result class=%0d kind=%0d len=%0d idx=%0d",
                             $realtime, cls, kind, len, idx);
                return;
            end
            e = owed_q.pop_front();
            if (e.cls !== cls || e.kind !== kind || e.len !== len || e.idx !== idx) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: mismatch exp class=%0d kind=%0d len=%0d idx=%0d",
                             $realtime, e.cls, e.kind, e.len, e.idx,
                             ", got %0d %0d %0d %0d", cls, kind, len, idx);
            end
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [7:0] i_data_byte;
    logic o_valid;
    logic i_stall;
    logic [ftpclt_pkg::BYTE_CLASS_W-1:0] o_byte_class;
    logic [ftpclt_pkg::TOKEN_KIND_W-1:0] o_token_kind;
    logic [ftpclt_pkg::TOKEN_LENGTH_W-1:0] o_token_length;
    logic [ftpclt_pkg::ARG_INDEX_W-1:0] o_arg_index;

    line_parse_tracker tracker = new();

    int burst_left = 0;
    bit sender_gapless = 1'b0;
    int sent_bytes = 0;
    bit hold_request = 1'b0;
    t_rx_mode stall_mode = RX_FREE;
    int mode_left = 0;
    int rx_tick = 0;
    logic [7:0] opening_bytes[$];

    ftp_command_line_tokenizer_core #(
        .TOKEN_LEN_MAX(TOKEN_LIMIT),
        .ARG_COUNT_MAX(ARG_LIMIT)
    ) dut (.*);

    always #1 i_clk = ~i_clk;

    // Byte that never ends a token
    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == ftpclt_pkg::BYTE_SP || b == ftpclt_pkg::BYTE_CR);
        return b;
    endfunction

    // Byte that breaks a CR LF pair
    function automatic logic [7:0] non_lf_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == ftpclt_pkg::BYTE_LF);
        return b;
    endfunction

    // One byte transfer, with a random gap ahead of each burst
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gapless ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                i_data_byte <= 8'($urandom);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        tracker.classify_byte(b);
        sent_bytes++;
    endtask

    // Stop offering bytes until every owed result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.owed() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed command line; first argument may be given a fixed length
    task automatic send_command(input int name_len, input int n_args, input int first_arg_len);
        int len;
        if ($urandom_range(0, 6) == 0) begin
            send_byte(ftpclt_pkg::BYTE_IAC);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
        send_byte(8'($urandom_range(0, 254)));
        repeat (name_len - 1) send_byte(token_byte());
        for (int a = 0; a < n_args; a++) begin
            repeat ($urandom_range(1, 3)) send_byte(ftpclt_pkg::BYTE_SP);
            len = (a == 0 && first_arg_len != 0) ? first_arg_len : $urandom_range(1, 6);
            repeat (len) send_byte(token_byte());
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(ftpclt_pkg::BYTE_SP);
        send_byte(ftpclt_pkg::BYTE_CR);
        if ($urandom_range(0, 9) == 0) send_byte(non_lf_byte());
        else send_byte(ftpclt_pkg::BYTE_LF);
    endtask

    // Result side: accept and check
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            tracker.compare_result(o_byte_class, o_token_kind, o_token_length, o_arg_index);
    end

    // Result-side stall: stretches of different patterns, plus a long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_stall <= (rx_tick % 3 == 0);
                    default:     i_stall <= 1'b0;
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int name_len;
        int n_args;
        int first_arg_len;
        int cmd;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        opening_bytes = '{
            // IAC swallows the next two bytes, whatever they are
            ftpclt_pkg::BYTE_IAC, ftpclt_pkg::BYTE_IAC, ftpclt_pkg::BYTE_CR,
            // space opens the name; one argument closed by CR
            ftpclt_pkg::BYTE_SP, 8'h00, ftpclt_pkg::BYTE_SP, ftpclt_pkg::BYTE_SP, 8'hFF,
            ftpclt_pkg::BYTE_CR, ftpclt_pkg::BYTE_LF,
            // CR opens the name, CR closes it, then a byte other than LF
            ftpclt_pkg::BYTE_CR, ftpclt_pkg::BYTE_CR, 8'h7E,
            // IAC and LF inside a name; CR right after separators
            8'h55, ftpclt_pkg::BYTE_IAC, ftpclt_pkg::BYTE_LF, ftpclt_pkg::BYTE_SP,
            ftpclt_pkg::BYTE_SP, ftpclt_pkg::BYTE_CR, ftpclt_pkg::BYTE_LF,
            // argument closed by a space right before CR
            8'hAA, ftpclt_pkg::BYTE_SP, 8'h01, ftpclt_pkg::BYTE_SP, ftpclt_pkg::BYTE_CR,
            ftpclt_pkg::BYTE_LF
        };
        foreach (opening_bytes[k]) send_byte(opening_bytes[k]);
        drain();

        cmd = 0;
        while (sent_bytes < STREAM_BYTES) begin
            if (cmd % 8 == 0) sender_gapless = ($urandom_range(0, 3) == 0);
            // long receiver hold while the sender keeps offering bytes
            if (cmd == 2) hold_request = 1'b1;
            if (cmd != 1 && cmd != LONG_CMD && $urandom_range(0, 7) == 0) begin
                // raw noise, parser left wherever it lands
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            end else begin
                name_len = $urandom_range(1, 8);
                n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                                     : $urandom_range(0, 4);
                // enough arguments to saturate the count
                if (cmd == 1) n_args = $urandom_range(16, 18);
                first_arg_len = 0;
                if (cmd == LONG_CMD) begin
                    // one token long enough to saturate its length count
                    if ($urandom_range(0, 1) == 0) begin
                        name_len = $urandom_range(1024, 1027);
                    end else begin
                        first_arg_len = $urandom_range(1024, 1027);
                        if (n_args == 0) n_args = 1;
                    end
                end
                send_command(name_len, n_args, first_arg_len);
            end
            if (cmd == 1 || cmd == LONG_CMD) drain();
            cmd++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.owed() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
